// File: src/rci_pkg.sv
package rci_pkg;

   typedef logic signed [31:0] fix_type;

   localparam fix_type FIX_MAX = 32'sh7fff_ffff;
   localparam fix_type FIX_MIN = 32'sh8000_0000;

   localparam int REQ_W  = 320;
   localparam int RSP_W  = 256;
   localparam int CSR_AW = 3;
   localparam int TOL_W  = 17;

   localparam logic [TOL_W-1:0] TOL_RESET   = 17'd66;
   localparam logic             CSR_IDX_TOL = 1'b0;

   localparam int SQ_ITER    = 24;
   localparam int SQ_PER     = 2;
   localparam int SQ_STAGES  = SQ_ITER / SQ_PER;
   localparam int DIV_ITER   = 32;
   localparam int DIV_PER    = 2;
   localparam int DIV_STAGES = DIV_ITER / DIV_PER + 2;

   localparam int ST_IN   = 0;
   localparam int ST_MUL1 = 1;
   localparam int ST_ABC  = 2;
   localparam int ST_MUL2 = 3;
   localparam int ST_DISC = 4;
   localparam int ST_SQ   = 5;
   localparam int ST_NUM  = ST_SQ + SQ_STAGES;
   localparam int ST_DIV1 = ST_NUM + 1;
   localparam int ST_ZMUL = ST_DIV1 + DIV_STAGES;
   localparam int ST_ZADD = ST_ZMUL + 1;
   localparam int ST_SEL  = ST_ZADD + 1;
   localparam int ST_PMUL = ST_SEL + 1;
   localparam int ST_PADD = ST_PMUL + 1;
   localparam int ST_DIV2 = ST_PADD + 1;
   localparam int ST_OUT  = ST_DIV2 + DIV_STAGES;
   localparam int NSTAGE  = ST_OUT + 1;

   typedef struct packed {
      fix_type          rad;
      fix_type          e0;
      fix_type          e1;
      fix_type          ox;
      fix_type          oy;
      fix_type          oz;
      fix_type          dx;
      fix_type          dy;
      fix_type          dz;
      logic [30:0]      len;
      logic [6:0][62:0] prod;
      logic [6:0]       pneg;
      fix_type          a;
      fix_type          b;
      fix_type          c;
      fix_type          disc;
      fix_type          nb;
      fix_type          pzmid;
      logic             za;
      logic             zc;
      logic             disc_ok;
      logic [23:0]      root;
      fix_type          num0;
      fix_type          num1;
      fix_type          den;
      logic             den_ok;
      fix_type          quot0;
      fix_type          quot1;
      fix_type          z0;
      fix_type          z1;
      logic             hit;
      fix_type          q;
      fix_type          px;
      fix_type          py;
      fix_type          pz;
      fix_type          hdist;
   } item_type;

   function automatic fix_type sat_add(fix_type x, fix_type y);
      logic [32:0] s;
      s = {x[31], x} + {y[31], y};
      if (s[32] != s[31]) begin
         return s[32] ? FIX_MIN : FIX_MAX;
      end
      return s[31:0];
   endfunction

   function automatic fix_type sat_sub(fix_type x, fix_type y);
      logic [32:0] s;
      s = {x[31], x} - {y[31], y};
      if (s[32] != s[31]) begin
         return s[32] ? FIX_MIN : FIX_MAX;
      end
      return s[31:0];
   endfunction

   function automatic fix_type sat_neg(fix_type x);
      return (x == FIX_MIN) ? FIX_MAX : -x;
   endfunction

   function automatic logic [31:0] mag(fix_type x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

   function automatic logic [62:0] umul(logic [31:0] x, logic [31:0] y);
      logic [63:0] p;
      p = x * y;
      return p[62:0];
   endfunction

   // drop the fraction of a magnitude product, saturate, apply sign
   function automatic fix_type mul_fin(logic [62:0] p, logic neg);
      logic [46:0] r;
      logic [31:0] lim;
      r   = p[62:16];
      lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      if (r > {15'd0, lim}) begin
         r = {15'd0, lim};
      end
      return neg ? (~r[31:0] + 32'd1) : r[31:0];
   endfunction

   function automatic fix_type div_fin(logic [31:0] quo, logic ovf, logic neg);
      logic [31:0] lim;
      logic [31:0] r;
      lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      r   = (ovf || quo > lim) ? lim : quo;
      return neg ? (~r + 32'd1) : r;
   endfunction

   function automatic logic is_small(fix_type x, logic [TOL_W-1:0] tol);
      return mag(x) < {15'd0, tol};
   endfunction

   function automatic logic between(fix_type z, fix_type e0, fix_type e1);
      return ((e0 < e1) && (z >= e0) && (z <= e1)) || ((e1 < e0) && (z >= e1) && (z <= e0));
   endfunction

endpackage

// File: src/rci_ctrl.sv
module rci_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        out_ready,
   output logic [rci_pkg::NSTAGE-1:0]  en,
   output logic                        out_valid
);

   localparam int N = rci_pkg::NSTAGE;

   logic [N-1:0] v_ff;
   logic [N-1:0] v_in;

   // a stage loads when it is empty or its item moves on
   always_comb begin
      en[N-1] = !v_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = in_valid;
      end
      for (int i = 1; i < N; i++) begin
         if (en[i]) begin
            v_in[i] = v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign out_valid = v_ff[N-1];

   assert property (@(posedge clock) disable iff (reset)
      (en[0] && v_ff[N-1] && !out_ready) |-> ($countones(v_ff) < N))
      else $error("input taken with no bubble in the pipe");

   assert property (@(posedge clock) disable iff (reset)
      (($countones(v_ff) == N) && !out_ready) |-> !en[0])
      else $error("full pipe accepted an item");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(v_ff) == $past($countones(v_ff))
                + int'($past(in_valid && en[0]))
                - int'($past(v_ff[N-1] && out_ready))))
      else $error("item count not conserved");

endmodule

// File: src/rci_sqrt.sv
module rci_sqrt (
   input  logic                           clock,
   input  logic [rci_pkg::SQ_STAGES-1:0]  en,
   input  rci_pkg::item_type              item_in,
   output rci_pkg::item_type              item_out
);

   localparam int N = rci_pkg::SQ_STAGES;

   rci_pkg::item_type item_ff [N];
   logic [47:0]       rad_ff  [N];
   logic [25:0]       rem_ff  [N];
   logic [23:0]       root_ff [N];

   rci_pkg::item_type item_src [N+1];
   logic [47:0]       rad_src  [N+1];
   logic [25:0]       rem_src  [N+1];
   logic [23:0]       root_src [N+1];

   assign item_src[0] = item_in;
   assign rad_src[0]  = {1'b0, item_in.disc[30:0], 16'd0};
   assign rem_src[0]  = '0;
   assign root_src[0] = '0;

   for (genvar k = 0; k < N; k++) begin : g_st
      rci_pkg::item_type item_nx;
      logic [47:0]       rad_in;
      logic [25:0]       rem_in;
      logic [23:0]       root_in;
      logic [27:0]       acc;
      logic [25:0]       trial;

      // two result bits per stage
      always_comb begin
         rad_in  = rad_src[k];
         rem_in  = rem_src[k];
         root_in = root_src[k];
         acc     = '0;
         trial   = '0;
         for (int j = 0; j < rci_pkg::SQ_PER; j++) begin
            acc   = {rem_in, rad_in[47:46]};
            trial = {root_in, 2'b01};
            if (acc >= {2'b00, trial}) begin
               rem_in  = 26'(acc - {2'b00, trial});
               root_in = {root_in[22:0], 1'b1};
            end else begin
               rem_in  = acc[25:0];
               root_in = {root_in[22:0], 1'b0};
            end
            rad_in = {rad_in[45:0], 2'b00};
         end
         item_nx      = item_src[k];
         item_nx.root = root_in;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            item_ff[k] <= item_nx;
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end

      assign item_src[k+1] = item_ff[k];
      assign rad_src[k+1]  = rad_ff[k];
      assign rem_src[k+1]  = rem_ff[k];
      assign root_src[k+1] = root_ff[k];
   end

   assign item_out = item_src[N];

endmodule

// File: src/rci_div.sv
module rci_div (
   input  logic                            clock,
   input  logic [rci_pkg::DIV_STAGES-1:0]  en,
   input  rci_pkg::item_type               item_in,
   output rci_pkg::item_type               item_out
);

   localparam int N = rci_pkg::DIV_STAGES;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
      logic        neg;
      logic        ovf;
   } lane_type;

   typedef struct packed {
      rci_pkg::item_type item;
      logic [31:0]       md;
      lane_type [1:0]    lane;
   } dstage_type;

   dstage_type st_ff  [N];
   dstage_type st_src [N+1];

   assign st_src[0] = '{item: item_in, md: '0, lane: '0};

   for (genvar k = 0; k < N; k++) begin : g_st
      dstage_type       st_in;
      logic [31:0]      m;
      logic [32:0]      acc;
      rci_pkg::fix_type num;

      always_comb begin
         st_in = st_src[k];
         m     = '0;
         acc   = '0;
         num   = '0;
         if (k == 0) begin
            // split |num| * 2^16: the high half seeds the remainder
            st_in.md = rci_pkg::mag(st_in.item.den);
            for (int l = 0; l < 2; l++) begin
               num                = (l == 0) ? st_in.item.num0 : st_in.item.num1;
               m                  = rci_pkg::mag(num);
               st_in.lane[l].rem  = {16'd0, m[31:16]};
               st_in.lane[l].low  = {m[15:0], 16'd0};
               st_in.lane[l].quo  = '0;
               st_in.lane[l].neg  = num[31] ^ st_in.item.den[31];
               st_in.lane[l].ovf  = {16'd0, m[31:16]} >= st_in.md;
            end
         end else if (k == N - 1) begin
            st_in.item.quot0 = rci_pkg::div_fin(st_in.lane[0].quo, st_in.lane[0].ovf,
                                                st_in.lane[0].neg);
            st_in.item.quot1 = rci_pkg::div_fin(st_in.lane[1].quo, st_in.lane[1].ovf,
                                                st_in.lane[1].neg);
         end else begin
            for (int l = 0; l < 2; l++) begin
               for (int j = 0; j < rci_pkg::DIV_PER; j++) begin
                  acc               = {st_in.lane[l].rem, st_in.lane[l].low[31]};
                  st_in.lane[l].low = {st_in.lane[l].low[30:0], 1'b0};
                  if (acc >= {1'b0, st_in.md}) begin
                     st_in.lane[l].rem = 32'(acc - {1'b0, st_in.md});
                     st_in.lane[l].quo = {st_in.lane[l].quo[30:0], 1'b1};
                  end else begin
                     st_in.lane[l].rem = acc[31:0];
                     st_in.lane[l].quo = {st_in.lane[l].quo[30:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            st_ff[k] <= st_in;
         end
      end

      assign st_src[k+1] = st_ff[k];
   end

   assign item_out = st_src[N].item;

endmodule

// File: src/ray_cylinder_intersect.sv
// Ray against a finite cylinder about the z axis, Q16.16 fixed point.
// req channel: one item per ray and cylinder; rsp channel: one item per
// request, in order. rsp_tuser carries the hit flag; on a miss every field
// of rsp_tdata is zero.
// Fully pipelined: a new item may be accepted every cycle unless a stalled
// rsp has filled every stage. Depth is set by the square root (12 stages,
// two bits each) and the two dividers (18 stages each; all but the first
// and last take two quotient bits per stage). Each stage holds its item
// until the next stage can take it, so a stalled receiver first fills
// bubbles; req_tready drops only when every stage holds an item and the
// result is not taken. Reset clears all valid bits and sets zero_tolerance
// to 66; the user must write it through the csr port at byte address 0
// only while the block is idle, which the block itself does not enforce.
module ray_cylinder_intersect (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // radius, end_low_z, end_high_z, origin_x/y/z, dir_x/y/z, dir_length
   input  logic [rci_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // point_x/y/z, normal_x/y/z, hit_distance, ray_param
   output logic [rci_pkg::RSP_W-1:0]    rsp_tdata,
   // hit
   output logic                         rsp_tuser,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rci_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [rci_pkg::NSTAGE-1:0] en;
   logic [rci_pkg::TOL_W-1:0]  tol_ff;
   logic [rci_pkg::TOL_W-1:0]  tol_in;

   rci_pkg::item_type in_ff,   in_in;
   rci_pkg::item_type mul1_ff, mul1_in;
   rci_pkg::item_type abc_ff,  abc_in;
   rci_pkg::item_type mul2_ff, mul2_in;
   rci_pkg::item_type disc_ff, disc_in;
   rci_pkg::item_type num_ff,  num_in;
   rci_pkg::item_type zmul_ff, zmul_in;
   rci_pkg::item_type zadd_ff, zadd_in;
   rci_pkg::item_type sel_ff,  sel_in;
   rci_pkg::item_type pmul_ff, pmul_in;
   rci_pkg::item_type padd_ff, padd_in;
   rci_pkg::item_type out_ff,  out_in;
   rci_pkg::item_type sq_out;
   rci_pkg::item_type div1_out;
   rci_pkg::item_type div2_out;

   logic             sel_c0;
   logic             sel_c1;
   rci_pkg::fix_type padd_px;
   rci_pkg::fix_type padd_py;
   rci_pkg::fix_type num_ds;

   // csr
   always_comb begin
      tol_in = tol_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == rci_pkg::CSR_IDX_TOL) begin
         tol_in = csr_pwdata[rci_pkg::TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= rci_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == rci_pkg::CSR_IDX_TOL) ? {15'd0, tol_ff} : 32'd0;

   rci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .en        (en),
      .out_valid (rsp_tvalid)
   );

   assign req_tready = en[rci_pkg::ST_IN];

   always_comb begin
      in_in     = '0;
      in_in.rad = req_tdata[31:0];
      in_in.e0  = req_tdata[63:32];
      in_in.e1  = req_tdata[95:64];
      in_in.ox  = req_tdata[127:96];
      in_in.oy  = req_tdata[159:128];
      in_in.oz  = req_tdata[191:160];
      in_in.dx  = req_tdata[223:192];
      in_in.dy  = req_tdata[255:224];
      in_in.dz  = req_tdata[287:256];
      in_in.len = req_tdata[318:288];
   end

   // squares and origin-direction products of the xy terms, and the radius squared
   always_comb begin
      mul1_in         = in_ff;
      mul1_in.prod[0] = rci_pkg::umul(rci_pkg::mag(in_ff.dx), rci_pkg::mag(in_ff.dx));
      mul1_in.prod[1] = rci_pkg::umul(rci_pkg::mag(in_ff.dy), rci_pkg::mag(in_ff.dy));
      mul1_in.prod[2] = rci_pkg::umul(rci_pkg::mag(in_ff.ox), rci_pkg::mag(in_ff.dx));
      mul1_in.prod[3] = rci_pkg::umul(rci_pkg::mag(in_ff.oy), rci_pkg::mag(in_ff.dy));
      mul1_in.prod[4] = rci_pkg::umul(rci_pkg::mag(in_ff.ox), rci_pkg::mag(in_ff.ox));
      mul1_in.prod[5] = rci_pkg::umul(rci_pkg::mag(in_ff.oy), rci_pkg::mag(in_ff.oy));
      mul1_in.prod[6] = rci_pkg::umul(rci_pkg::mag(in_ff.rad), rci_pkg::mag(in_ff.rad));
      mul1_in.pneg    = '0;
      mul1_in.pneg[2] = in_ff.ox[31] ^ in_ff.dx[31];
      mul1_in.pneg[3] = in_ff.oy[31] ^ in_ff.dy[31];
   end

   always_comb begin
      abc_in   = mul1_ff;
      abc_in.a = rci_pkg::sat_add(rci_pkg::mul_fin(mul1_ff.prod[0], mul1_ff.pneg[0]),
                                  rci_pkg::mul_fin(mul1_ff.prod[1], mul1_ff.pneg[1]));
      abc_in.b = rci_pkg::sat_add(rci_pkg::mul_fin(mul1_ff.prod[2], mul1_ff.pneg[2]),
                                  rci_pkg::mul_fin(mul1_ff.prod[3], mul1_ff.pneg[3]));
      abc_in.c = rci_pkg::sat_sub(
                    rci_pkg::sat_add(rci_pkg::mul_fin(mul1_ff.prod[4], mul1_ff.pneg[4]),
                                     rci_pkg::mul_fin(mul1_ff.prod[5], mul1_ff.pneg[5])),
                    rci_pkg::mul_fin(mul1_ff.prod[6], mul1_ff.pneg[6]));
   end

   always_comb begin
      mul2_in         = abc_ff;
      mul2_in.prod[0] = rci_pkg::umul(rci_pkg::mag(abc_ff.b), rci_pkg::mag(abc_ff.b));
      mul2_in.prod[1] = rci_pkg::umul(rci_pkg::mag(abc_ff.a), rci_pkg::mag(abc_ff.c));
      mul2_in.pneg[0] = 1'b0;
      mul2_in.pneg[1] = abc_ff.a[31] ^ abc_ff.c[31];
   end

   always_comb begin
      disc_in         = mul2_ff;
      disc_in.disc    = rci_pkg::sat_sub(rci_pkg::mul_fin(mul2_ff.prod[0], mul2_ff.pneg[0]),
                                         rci_pkg::mul_fin(mul2_ff.prod[1], mul2_ff.pneg[1]));
      disc_in.disc_ok = !disc_in.disc[31];
      disc_in.za      = rci_pkg::is_small(mul2_ff.a, tol_ff);
      disc_in.zc      = rci_pkg::is_small(mul2_ff.c, tol_ff);
      disc_in.nb      = rci_pkg::sat_neg(mul2_ff.b);
      // floor of the mean height, no overflow
      disc_in.pzmid   = (mul2_ff.e0 >>> 1) + (mul2_ff.e1 >>> 1)
                        + $signed({31'd0, mul2_ff.e0[0] & mul2_ff.e1[0]});
   end

   rci_sqrt u_sqrt (
      .clock    (clock),
      .en       (en[rci_pkg::ST_SQ +: rci_pkg::SQ_STAGES]),
      .item_in  (disc_ff),
      .item_out (sq_out)
   );

   assign num_ds = {8'd0, sq_out.root};

   // parallel rays divide by dir_z, the rest by a
   always_comb begin
      num_in        = sq_out;
      num_in.num0   = sq_out.za ? rci_pkg::sat_sub(sq_out.pzmid, sq_out.oz)
                                : rci_pkg::sat_sub(sq_out.nb, num_ds);
      num_in.num1   = rci_pkg::sat_add(sq_out.nb, num_ds);
      num_in.den    = sq_out.za ? sq_out.dz : sq_out.a;
      num_in.den_ok = sq_out.za ? (sq_out.dz != '0) : (sq_out.a != '0);
   end

   rci_div u_div1 (
      .clock    (clock),
      .en       (en[rci_pkg::ST_DIV1 +: rci_pkg::DIV_STAGES]),
      .item_in  (num_ff),
      .item_out (div1_out)
   );

   always_comb begin
      zmul_in         = div1_out;
      zmul_in.prod[0] = rci_pkg::umul(rci_pkg::mag(div1_out.dz), rci_pkg::mag(div1_out.quot0));
      zmul_in.prod[1] = rci_pkg::umul(rci_pkg::mag(div1_out.dz), rci_pkg::mag(div1_out.quot1));
      zmul_in.pneg[0] = div1_out.dz[31] ^ div1_out.quot0[31];
      zmul_in.pneg[1] = div1_out.dz[31] ^ div1_out.quot1[31];
   end

   always_comb begin
      zadd_in    = zmul_ff;
      zadd_in.z0 = rci_pkg::sat_add(zmul_ff.oz, rci_pkg::mul_fin(zmul_ff.prod[0], zmul_ff.pneg[0]));
      zadd_in.z1 = rci_pkg::sat_add(zmul_ff.oz, rci_pkg::mul_fin(zmul_ff.prod[1], zmul_ff.pneg[1]));
   end

   assign sel_c0 = !zadd_ff.quot0[31] && rci_pkg::between(zadd_ff.z0, zadd_ff.e0, zadd_ff.e1);
   assign sel_c1 = !zadd_ff.quot1[31] && rci_pkg::between(zadd_ff.z1, zadd_ff.e0, zadd_ff.e1);

   // nearer root first
   always_comb begin
      sel_in = zadd_ff;
      if (zadd_ff.za) begin
         sel_in.hit = zadd_ff.disc_ok && zadd_ff.zc && zadd_ff.den_ok && !zadd_ff.quot0[31];
         sel_in.q   = zadd_ff.quot0;
         sel_in.pz  = zadd_ff.pzmid;
      end else begin
         sel_in.hit = zadd_ff.disc_ok && zadd_ff.den_ok && (sel_c0 || sel_c1);
         sel_in.q   = sel_c0 ? zadd_ff.quot0 : zadd_ff.quot1;
         sel_in.pz  = sel_c0 ? zadd_ff.z0 : zadd_ff.z1;
      end
   end

   always_comb begin
      pmul_in         = sel_ff;
      pmul_in.prod[0] = rci_pkg::umul(rci_pkg::mag(sel_ff.dx), rci_pkg::mag(sel_ff.q));
      pmul_in.prod[1] = rci_pkg::umul(rci_pkg::mag(sel_ff.dy), rci_pkg::mag(sel_ff.q));
      pmul_in.prod[2] = rci_pkg::umul({1'b0, sel_ff.len}, rci_pkg::mag(sel_ff.q));
      pmul_in.pneg[0] = sel_ff.dx[31] ^ sel_ff.q[31];
      pmul_in.pneg[1] = sel_ff.dy[31] ^ sel_ff.q[31];
      pmul_in.pneg[2] = sel_ff.q[31];
   end

   assign padd_px = pmul_ff.za ? pmul_ff.ox
                   : rci_pkg::sat_add(pmul_ff.ox,
                                      rci_pkg::mul_fin(pmul_ff.prod[0], pmul_ff.pneg[0]));
   assign padd_py = pmul_ff.za ? pmul_ff.oy
                   : rci_pkg::sat_add(pmul_ff.oy,
                                      rci_pkg::mul_fin(pmul_ff.prod[1], pmul_ff.pneg[1]));

   // normal points inward when the ends are given rising
   always_comb begin
      padd_in       = pmul_ff;
      padd_in.px    = padd_px;
      padd_in.py    = padd_py;
      padd_in.hdist = rci_pkg::mul_fin(pmul_ff.prod[2], pmul_ff.pneg[2]);
      padd_in.num0  = (pmul_ff.e1 > pmul_ff.e0) ? rci_pkg::sat_neg(padd_px) : padd_px;
      padd_in.num1  = (pmul_ff.e1 > pmul_ff.e0) ? rci_pkg::sat_neg(padd_py) : padd_py;
      padd_in.den   = pmul_ff.rad;
      padd_in.hit   = pmul_ff.hit && (pmul_ff.rad != '0);
   end

   rci_div u_div2 (
      .clock    (clock),
      .en       (en[rci_pkg::ST_DIV2 +: rci_pkg::DIV_STAGES]),
      .item_in  (padd_ff),
      .item_out (div2_out)
   );

   always_comb begin
      out_in = div2_out;
      if (!div2_out.hit) begin
         out_in.px    = '0;
         out_in.py    = '0;
         out_in.pz    = '0;
         out_in.quot0 = '0;
         out_in.quot1 = '0;
         out_in.hdist = '0;
         out_in.q     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[rci_pkg::ST_IN]) begin
         in_ff <= in_in;
      end
      if (en[rci_pkg::ST_MUL1]) begin
         mul1_ff <= mul1_in;
      end
      if (en[rci_pkg::ST_ABC]) begin
         abc_ff <= abc_in;
      end
      if (en[rci_pkg::ST_MUL2]) begin
         mul2_ff <= mul2_in;
      end
      if (en[rci_pkg::ST_DISC]) begin
         disc_ff <= disc_in;
      end
      if (en[rci_pkg::ST_NUM]) begin
         num_ff <= num_in;
      end
      if (en[rci_pkg::ST_ZMUL]) begin
         zmul_ff <= zmul_in;
      end
      if (en[rci_pkg::ST_ZADD]) begin
         zadd_ff <= zadd_in;
      end
      if (en[rci_pkg::ST_SEL]) begin
         sel_ff <= sel_in;
      end
      if (en[rci_pkg::ST_PMUL]) begin
         pmul_ff <= pmul_in;
      end
      if (en[rci_pkg::ST_PADD]) begin
         padd_ff <= padd_in;
      end
      if (en[rci_pkg::ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tuser = out_ff.hit;
   assign rsp_tdata = {2'b00, out_ff.q[30:0], out_ff.hdist[30:0], 32'd0,
                       out_ff.quot1, out_ff.quot0, out_ff.pz, out_ff.py, out_ff.px};

endmodule
